// File: rtl/core/aic_pkg.sv
// ----------------------------------------------------------------------------
// aic_pkg
// Shared types, constants and command codes of the analog input conditioner.
// ----------------------------------------------------------------------------
package aic_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int WIN_MAX     = 32;
  localparam int WIN_AW      = $clog2(WIN_MAX);
  localparam int FILL_W      = WIN_AW + 1;
  localparam int Q_W         = 24;
  localparam int DIVD_W      = 38;
  localparam int DIVS_W      = 12;

  localparam logic [16:0] ALPHA_ONE = 17'h10000;

  localparam logic [2:0] REG_CONTROL   = 3'd0;
  localparam logic [2:0] REG_WINDOW    = 3'd1;
  localparam logic [2:0] REG_ALPHA     = 3'd2;
  localparam logic [2:0] REG_IN_MIN    = 3'd3;
  localparam logic [2:0] REG_IN_MAX    = 3'd4;
  localparam logic [2:0] REG_OUT_MIN   = 3'd5;
  localparam logic [2:0] REG_OUT_MAX   = 3'd6;
  localparam logic [2:0] REG_THRESHOLD = 3'd7;

  localparam logic [1:0] FILT_NONE = 2'd0;
  localparam logic [1:0] FILT_AVG  = 2'd1;
  localparam logic [1:0] FILT_COMP = 2'd2;
  localparam logic [1:0] FILT_MED  = 2'd3;

  localparam logic [4:0] OP_NOP     = 5'd0;
  localparam logic [4:0] OP_LOAD    = 5'd1;
  localparam logic [4:0] OP_CAL_CLR = 5'd2;
  localparam logic [4:0] OP_HOLD    = 5'd3;
  localparam logic [4:0] OP_MUL     = 5'd4;
  localparam logic [4:0] OP_SDIV    = 5'd5;
  localparam logic [4:0] OP_SPOST1  = 5'd6;
  localparam logic [4:0] OP_SPOST2  = 5'd7;
  localparam logic [4:0] OP_PASS    = 5'd8;
  localparam logic [4:0] OP_CMUL1   = 5'd9;
  localparam logic [4:0] OP_CMUL2   = 5'd10;
  localparam logic [4:0] OP_CSUM    = 5'd11;
  localparam logic [4:0] OP_PREAD   = 5'd12;
  localparam logic [4:0] OP_PUSH    = 5'd13;
  localparam logic [4:0] OP_ADIV    = 5'd14;
  localparam logic [4:0] OP_APOST   = 5'd15;
  localparam logic [4:0] OP_COPY    = 5'd16;
  localparam logic [4:0] OP_SORT    = 5'd17;
  localparam logic [4:0] OP_SHIFT   = 5'd18;
  localparam logic [4:0] OP_MPOST   = 5'd19;
  localparam logic [4:0] OP_FINISH  = 5'd20;

  typedef struct packed {
    logic [3:0]         control;
    logic [5:0]         window_size;
    logic [16:0]        alpha;
    logic [11:0]        in_min;
    logic [11:0]        in_max;
    logic signed [23:0] out_min;
    logic signed [23:0] out_max;
    logic [23:0]        threshold;
  } cfg_t;

  typedef struct packed {
    logic [4:0]        op;
    logic [FILL_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic              span_zero;
    logic [1:0]        mode;
    logic [FILL_W-1:0] fill;
    logic              div_done;
    logic              out_free;
  } stat_t;

endpackage

// File: rtl/core/aic_if.sv
// ----------------------------------------------------------------------------
// aic interfaces
// Sample, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface aic_smp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] sample;
  modport source (output valid, kind, sample, input ready);
  modport sink (input valid, kind, sample, output ready);
endinterface

interface aic_res_if;
  logic        valid;
  logic        ready;
  logic [23:0] value;
  logic        changed;
  modport source (output valid, value, changed, input ready);
  modport sink (input valid, value, changed, output ready);
endinterface

interface aic_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/analog_input_conditioner_core.sv
// ----------------------------------------------------------------------------
// analog_input_conditioner_core
// Scales 12-bit converter samples to signed Q15.8 and filters them.
//
// smp carries kind and sample; kind 1 resets the calibration min/max and
// gives no result. Every kind-0 item gives one item on res: the filtered
// value and the changed flag. cfg writes registers 0..7; it is always ready
// and must only be used while the block is idle.
// One item at a time: smp.ready is high only when idle. Scaling uses the
// shared divider, which is skipped on zero span. The median filter copies
// from the window RAM and runs an odd-even transposition sort, one pass per
// cycle. After the result is loaded the block returns to idle and takes
// the next item; a kind-1 item is taken without leaving idle.
// The result sits in an output register; a stalled receiver holds the next
// sample in its final state until the register frees. Reset is synchronous
// and restores register defaults, calibration and the window store.
// ----------------------------------------------------------------------------
module analog_input_conditioner_core
  import aic_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  aic_smp_if.sink   smp,
  aic_res_if.source res,
  aic_cfg_if.sink   cfg
);

  cfg_t  regs;
  logic  clr;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign smp.ready = in_ready;

  aic_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs),
    .clr  (clr)
  );

  aic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (smp.valid),
    .in_kind  (smp.kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aic_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .clr    (clr),
    .cmd    (cmd),
    .sample (smp.sample),
    .res    (res),
    .stat   (stat)
  );

`ifndef SYNTH
  a_cal_no_result: assert property (@(posedge clk) disable iff (rst)
    smp.valid && smp.ready && smp.kind |=> !$rose(res.valid))
    else $error("calibration reset produced a result");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    smp.valid && smp.ready && !smp.kind |=> !smp.ready)
    else $error("sample accepted without leaving idle");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> !$past(smp.ready))
    else $error("result raised while idle");
`endif

endmodule

// File: rtl/core/aic_regs.sv
// ----------------------------------------------------------------------------
// aic_regs
// Configuration register file; flags writes that clear the filter store.
// ----------------------------------------------------------------------------
module aic_regs
  import aic_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  aic_cfg_if.sink   cfg,
  output cfg_t      regs,
  output logic      clr
);

  assign cfg.ready = 1'b1;
  assign clr = cfg.valid && (cfg.index == REG_CONTROL || cfg.index == REG_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.control     <= 4'd0;
      regs.window_size <= 6'd1;
      regs.alpha       <= ALPHA_ONE;
      regs.in_min      <= 12'd0;
      regs.in_max      <= 12'd4095;
      regs.out_min     <= 24'sd0;
      regs.out_max     <= 24'sd1048320;
      regs.threshold   <= 24'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CONTROL:   regs.control     <= cfg.data[3:0];
        REG_WINDOW:    regs.window_size <= cfg.data[5:0];
        REG_ALPHA:     regs.alpha       <= cfg.data[16:0];
        REG_IN_MIN:    regs.in_min      <= cfg.data[11:0];
        REG_IN_MAX:    regs.in_max      <= cfg.data[11:0];
        REG_OUT_MIN:   regs.out_min     <= signed'(cfg.data);
        REG_OUT_MAX:   regs.out_max     <= signed'(cfg.data);
        REG_THRESHOLD: regs.threshold   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/aic_div.sv
// ----------------------------------------------------------------------------
// aic_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aic_div
  import aic_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic [DIVD_W-1:0] quot,
  output logic              done
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W+1:0] trial;

  assign shifted = {rem, quot[DIVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      if (!trial[DIVS_W+1]) begin
        rem  <= trial[DIVS_W-1:0];
        quot <= {quot[DIVD_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[DIVS_W-1:0];
        quot <= {quot[DIVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/core/aic_datapath.sv
// ----------------------------------------------------------------------------
// aic_datapath
// Calibration, scaling, window store, filters and result register.
// ----------------------------------------------------------------------------
module aic_datapath
  import aic_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            regs,
  input  logic            clr,
  input  cmd_t            cmd,
  input  logic [11:0]     sample,
  aic_res_if.source       res,
  output stat_t           stat
);

  logic [11:0]              cal_min, cal_max, sample_r;
  logic signed [37:0]       prod;
  logic                     neg_r;
  logic signed [39:0]       x1;
  logic signed [Q_W-1:0]    scaled, result, fv, prev;
  logic signed [41:0]       p1, p2;
  logic signed [28:0]       sum;
  logic [FILL_W-1:0]        fill;
  logic [WIN_AW-1:0]        slot;
  logic signed [Q_W-1:0]    rdata;
  logic signed [Q_W-1:0]    mem [WIN_MAX];
  logic signed [Q_W-1:0]    t [WIN_MAX];
  logic signed [Q_W-1:0]    t_next [WIN_MAX];
  logic [WIN_MAX-2:0]       swap;
  logic                     out_valid;

  logic [11:0]              lo, hi;
  logic signed [12:0]       span, diff;
  logic signed [24:0]       orng;
  logic signed [37:0]       prod_c;
  logic [11:0]              span_abs;
  logic [37:0]              prod_abs;
  logic [28:0]              sum_abs;
  logic [DIVD_W-1:0]        dvd, quot;
  logic [DIVS_W-1:0]        dvs;
  logic                     div_start, div_done;
  logic signed [39:0]       qs, xs, xi, omin40, omax40;
  logic [16:0]              a_sat, b_w;
  logic signed [42:0]       csum, cbias;
  logic signed [23:0]       aq;
  logic signed [24:0]       ms, mb, d;
  logic [24:0]              dabs;
  logic [FILL_W-1:0]        n_win;
  logic                     full;
  logic [WIN_AW-1:0]        raddr, cidx;

  assign lo       = regs.control[3] ? cal_min : regs.in_min;
  assign hi       = regs.control[3] ? cal_max : regs.in_max;
  assign span     = signed'({1'b0, hi}) - signed'({1'b0, lo});
  assign diff     = signed'({1'b0, sample_r}) - signed'({1'b0, lo});
  assign orng     = 25'(regs.out_max) - 25'(regs.out_min);
  assign prod_c   = 38'(diff) * 38'(orng);
  assign span_abs = span[12] ? 12'(-span) : span[11:0];
  assign prod_abs = prod[37] ? 38'(-prod) : 38'(prod);
  assign sum_abs  = sum[28] ? 29'(-sum) : 29'(sum);

  assign div_start = (cmd.op == OP_SDIV) || (cmd.op == OP_ADIV);
  assign dvd = (cmd.op == OP_SDIV) ? prod_abs : DIVD_W'(sum_abs);
  assign dvs = (cmd.op == OP_SDIV) ? span_abs : DIVS_W'(fill);

  aic_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quot     (quot),
    .done     (div_done)
  );

  assign omin40 = 40'(regs.out_min);
  assign omax40 = 40'(regs.out_max);
  assign qs     = neg_r ? -signed'({2'b00, quot}) : signed'({2'b00, quot});
  assign xs     = qs + omin40;
  assign xi     = regs.control[2] ? (omax40 + omin40 - xs) : xs;

  assign a_sat  = (regs.alpha > ALPHA_ONE) ? ALPHA_ONE : regs.alpha;
  assign b_w    = ALPHA_ONE - a_sat;
  assign csum   = 43'(p1) + 43'(p2);
  assign cbias  = csum + (csum[42] ? 43'sd65535 : 43'sd0);
  assign aq     = neg_r ? -signed'(quot[23:0]) : signed'(quot[23:0]);

  assign ms     = 25'(t[0]) + 25'(t[1]);
  assign mb     = ms + (ms[24] ? 25'sd1 : 25'sd0);

  assign d      = 25'(result) - 25'(prev);
  assign dabs   = d[24] ? 25'(-d) : 25'(d);

  assign n_win  = (regs.window_size == 6'd0) ? FILL_W'(1) :
                  (regs.window_size > 6'(WIN_MAX)) ? FILL_W'(WIN_MAX) :
                  FILL_W'(regs.window_size);
  assign full   = fill >= n_win;
  assign raddr  = (cmd.op == OP_COPY) ? cmd.cnt[WIN_AW-1:0] : slot;
  assign cidx   = WIN_AW'(cmd.cnt - 1'b1);

  always_comb begin
    for (int i = 0; i < WIN_MAX - 1; i++) begin
      swap[i] = (1'(i) == cmd.cnt[0]) && (FILL_W'(i + 1) < fill) && (t[i] > t[i+1]);
    end
    for (int j = 0; j < WIN_MAX; j++) begin
      t_next[j] = t[j];
      if (j < WIN_MAX - 1) begin
        if (swap[j]) t_next[j] = t[j+1];
      end
      if (j > 0) begin
        if (swap[j-1]) t_next[j] = t[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (cmd.op == OP_PUSH) begin
      if (full) mem[slot] <= scaled;
      else      mem[fill[WIN_AW-1:0]] <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:   sample_r <= sample;
      OP_HOLD:   scaled   <= fv;
      OP_MUL:    prod     <= prod_c;
      OP_SDIV:   neg_r    <= prod[37] ^ span[12];
      OP_SPOST1: x1       <= xi;
      OP_SPOST2: begin
        if (x1 < omin40)      scaled <= regs.out_min;
        else if (x1 > omax40) scaled <= regs.out_max;
        else                  scaled <= x1[23:0];
      end
      OP_PASS:   result   <= scaled;
      OP_CMUL1:  p1       <= 42'(signed'({1'b0, a_sat})) * 42'(scaled);
      OP_CMUL2:  p2       <= 42'(signed'({1'b0, b_w})) * 42'(fv);
      OP_CSUM:   result   <= cbias[39:16];
      OP_ADIV:   neg_r    <= sum[28];
      OP_APOST:  result   <= aq;
      OP_COPY: begin
        if (cmd.cnt != '0) t[cidx] <= rdata;
      end
      OP_SORT:   t <= t_next;
      OP_SHIFT: begin
        for (int k = 0; k < WIN_MAX - 1; k++) t[k] <= t[k+1];
      end
      OP_MPOST:  result   <= fill[0] ? t[0] : mb[24:1];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_min   <= 12'd4095;
      cal_max   <= 12'd0;
      fill      <= '0;
      slot      <= '0;
      sum       <= '0;
      fv        <= '0;
      prev      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CAL_CLR) begin
        cal_min <= 12'd4095;
        cal_max <= 12'd0;
      end else if (cmd.op == OP_LOAD && regs.control[3]) begin
        if (sample < cal_min) cal_min <= sample;
        if (sample > cal_max) cal_max <= sample;
      end
      if (clr) begin
        fill <= '0;
        slot <= '0;
        sum  <= '0;
      end else if (cmd.op == OP_PUSH) begin
        if (full) begin
          sum  <= sum - 29'(rdata) + 29'(scaled);
          slot <= (FILL_W'(slot) + 1'b1 == n_win) ? '0 : slot + 1'b1;
        end else begin
          sum  <= sum + 29'(scaled);
          fill <= fill + 1'b1;
        end
      end
      if (cmd.op == OP_FINISH) begin
        fv        <= result;
        prev      <= result;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      res.value   <= result;
      res.changed <= dabs >= {1'b0, regs.threshold};
    end
  end

  assign res.valid      = out_valid;
  assign stat.span_zero = span == 13'sd0;
  assign stat.mode      = regs.control[1:0];
  assign stat.fill      = fill;
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid || res.ready;

endmodule

// File: rtl/core/aic_ctrl.sv
// ----------------------------------------------------------------------------
// aic_ctrl
// Sequencer for scaling, filter selection, median sort and result hand-off.
// ----------------------------------------------------------------------------
module aic_ctrl
  import aic_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_kind,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MUL    = 5'd1;
  localparam logic [4:0] S_SDIV   = 5'd2;
  localparam logic [4:0] S_SWAIT  = 5'd3;
  localparam logic [4:0] S_SPOST1 = 5'd4;
  localparam logic [4:0] S_SPOST2 = 5'd5;
  localparam logic [4:0] S_FILT   = 5'd6;
  localparam logic [4:0] S_CMUL2  = 5'd7;
  localparam logic [4:0] S_CSUM   = 5'd8;
  localparam logic [4:0] S_PUSH   = 5'd9;
  localparam logic [4:0] S_ADIV   = 5'd10;
  localparam logic [4:0] S_AWAIT  = 5'd11;
  localparam logic [4:0] S_APOST  = 5'd12;
  localparam logic [4:0] S_COPY   = 5'd13;
  localparam logic [4:0] S_SORT   = 5'd14;
  localparam logic [4:0] S_SHIFT  = 5'd15;
  localparam logic [4:0] S_MPOST  = 5'd16;
  localparam logic [4:0] S_DONE   = 5'd17;

  logic [4:0]        state, state_next;
  logic [FILL_W-1:0] cnt, cnt_next;
  logic [FILL_W-1:0] shifts;

  assign shifts   = (stat.fill - 1'b1) >> 1;
  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NOP;
    cmd.cnt    = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            cmd.op = OP_CAL_CLR;
          end else begin
            cmd.op     = OP_LOAD;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (stat.span_zero) begin
          cmd.op     = OP_HOLD;
          state_next = S_FILT;
        end else begin
          cmd.op     = OP_MUL;
          state_next = S_SDIV;
        end
      end
      S_SDIV: begin
        cmd.op     = OP_SDIV;
        state_next = S_SWAIT;
      end
      S_SWAIT: if (stat.div_done) state_next = S_SPOST1;
      S_SPOST1: begin
        cmd.op     = OP_SPOST1;
        state_next = S_SPOST2;
      end
      S_SPOST2: begin
        cmd.op     = OP_SPOST2;
        state_next = S_FILT;
      end
      S_FILT: begin
        case (stat.mode)
          FILT_NONE: begin
            cmd.op     = OP_PASS;
            state_next = S_DONE;
          end
          FILT_COMP: begin
            cmd.op     = OP_CMUL1;
            state_next = S_CMUL2;
          end
          default: begin
            cmd.op     = OP_PREAD;
            state_next = S_PUSH;
          end
        endcase
      end
      S_CMUL2: begin
        cmd.op     = OP_CMUL2;
        state_next = S_CSUM;
      end
      S_CSUM: begin
        cmd.op     = OP_CSUM;
        state_next = S_DONE;
      end
      S_PUSH: begin
        cmd.op   = OP_PUSH;
        cnt_next = '0;
        if (stat.mode == FILT_AVG) state_next = S_ADIV;
        else                       state_next = S_COPY;
      end
      S_ADIV: begin
        cmd.op     = OP_ADIV;
        state_next = S_AWAIT;
      end
      S_AWAIT: if (stat.div_done) state_next = S_APOST;
      S_APOST: begin
        cmd.op     = OP_APOST;
        state_next = S_DONE;
      end
      S_COPY: begin
        cmd.op = OP_COPY;
        if (cnt == stat.fill) begin
          cnt_next   = '0;
          state_next = S_SORT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SORT: begin
        cmd.op = OP_SORT;
        if (cnt == stat.fill - 1'b1) begin
          cnt_next   = '0;
          state_next = S_SHIFT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SHIFT: begin
        if (cnt == shifts) begin
          state_next = S_MPOST;
        end else begin
          cmd.op   = OP_SHIFT;
          cnt_next = cnt + 1'b1;
        end
      end
      S_MPOST: begin
        cmd.op     = OP_MPOST;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
